[hdl/kinematic_bicycle_step_unit_defines.svh]
// assertion macros for the kinematic bicycle step unit
`ifndef KINEMATIC_BICYCLE_STEP_UNIT_DEFINES_SVH
`define KINEMATIC_BICYCLE_STEP_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define KBS_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kbs check failed");
`define KBS_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kbs check failed");
`else
`define KBS_ASSERT_IMP(name, ante, cons)
`define KBS_ASSERT_NEXT(name, ante, cons)
`endif
`endif

[hdl/kbs_pkg.sv]
// shared types, constants and the arctangent table of the bicycle step unit
package kbs_pkg;

   localparam int ANG_W        = 16;
   localparam int MAX_STEPS    = 64;
   localparam int CORDIC_ITERS = 15;
   localparam int XY_W         = 52;
   localparam int Z_W          = 20;
   localparam int DIVD_W       = 36;
   localparam int PROD_W       = 68;

   localparam logic signed [XY_W-1:0] CORDIC_GAIN = 52'sd652032874;
   localparam logic signed [31:0]     RAD_TO_BAM  = 32'sd2670177;
   localparam logic signed [Z_W-1:0]  Z_QUARTER   = 20'sd16384;
   localparam logic signed [Z_W-1:0]  Z_HALF      = 20'sd32768;

   localparam logic [1:0] CSR_FRONT = 2'd0;
   localparam logic [1:0] CSR_REAR  = 2'd1;
   localparam logic [1:0] CSR_DT    = 2'd2;

   localparam logic [15:0] FRONT_RESET = 16'd4915;
   localparam logic [15:0] REAR_RESET  = 16'd6554;
   localparam logic [15:0] DT_RESET    = 16'd655;

   typedef enum logic {
      CM_ROT,
      CM_VEC
   } cordic_mode_type;

   typedef struct packed {
      logic            start;
      cordic_mode_type mode;
      logic [ANG_W-1:0] angle;
   } cordic_cmd_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_STR_ROT,
      S_STR_WAIT,
      S_MUL_Y,
      S_MUL_X,
      S_VEC,
      S_VEC_WAIT,
      S_SLIP_ROT,
      S_SLIP_WAIT,
      S_ACC,
      S_ACC_L,
      S_PV,
      S_HROT,
      S_HROT_WAIT,
      S_Q1,
      S_NUM,
      S_DIV,
      S_X,
      S_Y,
      S_DIV_WAIT
   } state_type;

   // arctangent of 2^-i in 2^-16 turn
   function automatic logic signed [Z_W-1:0] angle_step(input logic [3:0] i);
      logic signed [Z_W-1:0] r;
      unique case (i)
         4'd0:    r = 20'sd8192;
         4'd1:    r = 20'sd4836;
         4'd2:    r = 20'sd2555;
         4'd3:    r = 20'sd1297;
         4'd4:    r = 20'sd651;
         4'd5:    r = 20'sd326;
         4'd6:    r = 20'sd163;
         4'd7:    r = 20'sd81;
         4'd8:    r = 20'sd41;
         4'd9:    r = 20'sd20;
         4'd10:   r = 20'sd10;
         4'd11:   r = 20'sd5;
         4'd12:   r = 20'sd3;
         4'd13:   r = 20'sd1;
         4'd14:   r = 20'sd1;
         default: r = 20'sd0;
      endcase
      return r;
   endfunction

endpackage

[hdl/kbs_cordic.sv]
// iterative cordic, rotation and vectoring, one micro-rotation per cycle
module kbs_cordic (
   input  logic                                    clock,
   input  logic                                    reset,
   input  kbs_pkg::cordic_cmd_type                 cmd,
   input  logic signed [kbs_pkg::XY_W-1:0]         vec_x,
   input  logic signed [kbs_pkg::XY_W-1:0]         vec_y,
   output logic                                    done,
   output logic signed [31:0]                      cos_out,
   output logic signed [31:0]                      sin_out,
   output logic [kbs_pkg::ANG_W-1:0]               angle_out
);
   import kbs_pkg::*;

   logic signed [XY_W-1:0] x_ff, x_in, y_ff, y_in, dx, dy, xn, yn;
   logic signed [Z_W-1:0]  z_ff, z_in, z0, step;
   logic [3:0]             it_ff, it_in;
   logic                   busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in, up;
   cordic_mode_type        mode_ff, mode_in;

   // start setup and one iteration per cycle
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      it_in   = it_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      neg_in  = neg_ff;
      mode_in = mode_ff;
      dx      = y_ff >>> it_ff;
      dy      = x_ff >>> it_ff;
      step    = angle_step(it_ff);
      up      = (mode_ff == CM_ROT) ? !z_ff[Z_W-1] : (y_ff <= 0);
      z0      = {{(Z_W-ANG_W){cmd.angle[ANG_W-1]}}, cmd.angle};
      if (cmd.start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         it_in   = 4'd0;
         mode_in = cmd.mode;
         neg_in  = 1'b0;
         if (cmd.mode == CM_ROT) begin
            x_in = CORDIC_GAIN;
            y_in = '0;
            z_in = z0;
            // fold into the right half plane
            if (z0 > Z_QUARTER) begin
               z_in   = z0 - Z_HALF;
               neg_in = 1'b1;
            end else if (z0 < -Z_QUARTER) begin
               z_in   = z0 + Z_HALF;
               neg_in = 1'b1;
            end
         end else begin
            if (vec_x < 0) begin
               x_in = -vec_x;
               y_in = -vec_y;
               z_in = Z_HALF;
            end else begin
               x_in = vec_x;
               y_in = vec_y;
               z_in = '0;
            end
         end
      end else if (busy_ff) begin
         if (up) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - step;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + step;
         end
         it_in = it_ff + 4'd1;
         if (it_ff == 4'(CORDIC_ITERS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      it_ff   <= it_in;
      neg_ff  <= neg_in;
      mode_ff <= mode_in;
   end

   // undo the half-turn fold
   assign xn        = neg_ff ? -x_ff : x_ff;
   assign yn        = neg_ff ? -y_ff : y_ff;
   assign cos_out   = xn[31:0];
   assign sin_out   = yn[31:0];
   assign angle_out = z_ff[ANG_W-1:0];
   assign done      = done_ff;

endmodule

[hdl/kbs_div.sv]
// restoring unsigned divider, one quotient bit per cycle
module kbs_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [kbs_pkg::DIVD_W-1:0]    dividend,
   input  logic [15:0]                   divisor,
   output logic                          done,
   output logic [kbs_pkg::DIVD_W-1:0]    quotient
);
   import kbs_pkg::*;

   logic [15:0]       rem_ff, rem_in, dvs_ff, dvs_in;
   logic [DIVD_W-1:0] sh_ff, sh_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in, ge;
   logic [16:0]       trial, diff;

   // shift in one dividend bit, subtract when it fits
   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      sh_in   = sh_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      trial   = {rem_ff, sh_ff[DIVD_W-1]};
      ge      = trial >= {1'b0, dvs_ff};
      diff    = trial - {1'b0, dvs_ff};
      if (start) begin
         rem_in  = '0;
         dvs_in  = divisor;
         sh_in   = dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[15:0] : trial[15:0];
         sh_in  = {sh_ff[DIVD_W-2:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(DIVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      sh_ff  <= sh_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = sh_ff;

endmodule

[hdl/kinematic_bicycle_step_unit.sv]
// top level: sequencer, shared multiplier and state of the bicycle step unit
//
// Kinematic bicycle model advanced by Euler steps in fixed point.
// req channel: one transfer per item; tuser is the action (0 load, 1 run).
//   A load sets position, speed and heading, clears the tick count and
//   answers with one result in the next cycle.
//   A run holds accel and steer for step_count steps (0 gives nothing,
//   more than 64 runs 64) and answers with one result per step; tlast
//   marks the final one.
// rsp channel: one output register; the block stalls while it is full and
//   the receiver holds rsp_tready low, and resumes when it is taken.
// csr port: write-only, taken at any edge with csr_we high; write it only
//   while no item is in flight.
// Timing: one item at a time; req_tready is high only while idle.
//   A run first finds the slip angle (three cordic passes and the
//   multiplier), then takes each step through one cordic pass and then
//   the divider. One multiplier, one cordic unit and one divider are
//   shared.
// Reset: synchronous; state and tick count go to zero, registers to their
//   defaults, no result pending.
`include "kinematic_bicycle_step_unit_defines.svh"
module kinematic_bicycle_step_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // x_init[31:0], y_init[63:32], speed_init[87:64], heading_init[103:88],
   // accel[119:104], steer_angle[134:120], step_count[141:135], zero pad
   input  logic [143:0] req_tdata,
   // action
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tick_index[31:0], out_x[63:32], out_y[95:64], out_speed[119:96],
   // out_heading[135:120]
   output logic [135:0] rsp_tdata,
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);
   import kbs_pkg::*;

   state_type state_ff, state_in;

   logic [15:0]               front_ff, front_in, rear_ff, rear_in, dt_ff, dt_in, rr;
   logic signed [31:0]        x_ff, x_in, y_ff, y_in;
   logic signed [23:0]        spd_ff, spd_in;
   logic [15:0]               hdg_ff, hdg_in;
   logic [31:0]               tick_ff, tick_in;
   logic signed [15:0]        accel_ff, accel_in;
   logic [15:0]               steer_ff, steer_in;
   logic [6:0]                left_ff, left_in, req_steps;
   logic [15:0]               slip_ff, slip_in;
   logic signed [31:0]        c_ff, c_in, s_ff, s_in, sin_slip_ff, sin_slip_in;
   logic signed [31:0]        pv_ff, pv_in;
   logic signed [24:0]        dv_ff, dv_in;
   logic signed [XY_W-1:0]    vy_ff, vy_in;
   logic                      neg_ff, neg_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_sh8, prod_sh28, prod_sh38, num_mag;
   logic signed [35:0]        mul_a;
   logic signed [31:0]        mul_b;
   logic                      rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [135:0]              rsp_data_ff, rsp_data_in;
   logic                      accept, slot_free, last_step;
   logic [PROD_W-1:0]         div_num;
   logic [15:0]               delta, hdg_new;
   logic signed [33:0]        sum_x, sum_y;
   logic signed [25:0]        sum_spd;
   logic signed [31:0]        x_new, y_new;
   logic signed [23:0]        spd_new;

   cordic_cmd_type            cor_cmd;
   logic signed [XY_W-1:0]    cor_vx, cor_vy;
   logic                      cor_done;
   logic signed [31:0]        cor_cos, cor_sin;
   logic [ANG_W-1:0]          cor_ang;
   logic                      div_start, div_done;
   logic [DIVD_W-1:0]         div_dividend, div_q;

   kbs_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cor_cmd),
      .vec_x     (cor_vx),
      .vec_y     (cor_vy),
      .done      (cor_done),
      .cos_out   (cor_cos),
      .sin_out   (cor_sin),
      .angle_out (cor_ang)
   );

   kbs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (rr),
      .done     (div_done),
      .quotient (div_q)
   );

   // handshake and derived values
   assign accept    = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && slot_free;
   assign rr        = (rear_ff == 16'd0) ? 16'd1 : rear_ff;
   assign prod_sh8  = prod_ff >>> 8;
   assign prod_sh28 = prod_ff >>> 28;
   assign prod_sh38 = prod_ff >>> 38;
   assign req_steps = (req_tdata[141:135] > 7'(MAX_STEPS)) ? 7'(MAX_STEPS)
                                                           : req_tdata[141:135];
   assign last_step = (left_ff == 7'd1);

   // heading rounding: add half the divisor, drop the 2^22 scale, divide by rear
   assign num_mag      = prod_ff[PROD_W-1] ? -prod_ff : prod_ff;
   assign div_num      = PROD_W'(num_mag) + (PROD_W'(rr) << 21);
   assign div_dividend = div_num[57:22];
   assign delta        = neg_ff ? 16'(-div_q[15:0]) : div_q[15:0];
   assign hdg_new      = hdg_ff + delta;

   // position and speed with saturation
   assign sum_x   = 34'(x_ff) + prod_sh38[33:0];
   assign sum_y   = 34'(y_ff) + prod_sh38[33:0];
   assign x_new   = (sum_x > 34'sd2147483647) ? 32'sh7FFFFFFF :
                    (sum_x < -34'sd2147483648) ? 32'sh80000000 : sum_x[31:0];
   assign y_new   = (sum_y > 34'sd2147483647) ? 32'sh7FFFFFFF :
                    (sum_y < -34'sd2147483648) ? 32'sh80000000 : sum_y[31:0];
   assign sum_spd = 26'(spd_ff) + 26'(dv_ff);
   assign spd_new = (sum_spd > 26'sd8388607) ? 24'sh7FFFFF :
                    (sum_spd < -26'sd8388608) ? 24'sh800000 : sum_spd[23:0];

   // shared multiplier, one product per cycle
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // sequencer: next state, operand select and register updates
   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      rear_in       = rear_ff;
      dt_in         = dt_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      spd_in        = spd_ff;
      hdg_in        = hdg_ff;
      tick_in       = tick_ff;
      accel_in      = accel_ff;
      steer_in      = steer_ff;
      left_in       = left_ff;
      slip_in       = slip_ff;
      c_in          = c_ff;
      s_in          = s_ff;
      sin_slip_in   = sin_slip_ff;
      pv_in         = pv_ff;
      dv_in         = dv_ff;
      vy_in         = vy_ff;
      neg_in        = neg_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_last_in   = rsp_last_ff;
      rsp_data_in   = rsp_data_ff;
      mul_a         = '0;
      mul_b         = '0;
      cor_cmd.start = 1'b0;
      cor_cmd.mode  = CM_ROT;
      cor_cmd.angle = '0;
      cor_vx        = prod_ff[XY_W-1:0];
      cor_vy        = vy_ff;
      div_start     = 1'b0;

      // configuration writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_FRONT: front_in = csr_wdata;
            CSR_REAR:  rear_in  = csr_wdata;
            CSR_DT:    dt_in    = csr_wdata;
            default:   ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (!req_tuser) begin
                  x_in         = req_tdata[31:0];
                  y_in         = req_tdata[63:32];
                  spd_in       = req_tdata[87:64];
                  hdg_in       = req_tdata[103:88];
                  tick_in      = '0;
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = 1'b1;
                  rsp_data_in  = {req_tdata[103:88], req_tdata[87:64], req_tdata[63:32],
                                  req_tdata[31:0], 32'd0};
               end else if (req_steps != 7'd0) begin
                  accel_in = req_tdata[119:104];
                  steer_in = {req_tdata[134], req_tdata[134:120]};
                  left_in  = req_steps;
                  state_in = S_STR_ROT;
               end
            end
         end
         S_STR_ROT: begin
            cor_cmd.start = 1'b1;
            cor_cmd.angle = steer_ff;
            state_in      = S_STR_WAIT;
         end
         S_STR_WAIT: begin
            if (cor_done) begin
               c_in     = cor_cos;
               s_in     = cor_sin;
               state_in = S_MUL_Y;
            end
         end
         S_MUL_Y: begin
            mul_a    = 36'(s_ff);
            mul_b    = {16'd0, rr};
            state_in = S_MUL_X;
         end
         S_MUL_X: begin
            mul_a    = 36'(c_ff);
            mul_b    = {15'd0, {1'b0, front_ff} + {1'b0, rr}};
            vy_in    = prod_ff[XY_W-1:0];
            state_in = S_VEC;
         end
         S_VEC: begin
            cor_cmd.start = 1'b1;
            cor_cmd.mode  = CM_VEC;
            state_in      = S_VEC_WAIT;
         end
         S_VEC_WAIT: begin
            if (cor_done) begin
               slip_in  = cor_ang;
               state_in = S_SLIP_ROT;
            end
         end
         S_SLIP_ROT: begin
            cor_cmd.start = 1'b1;
            cor_cmd.angle = slip_ff;
            state_in      = S_SLIP_WAIT;
         end
         S_SLIP_WAIT: begin
            if (cor_done) begin
               sin_slip_in = cor_sin;
               state_in    = S_ACC;
            end
         end
         S_ACC: begin
            mul_a    = {20'd0, dt_ff};
            mul_b    = 32'(accel_ff);
            state_in = S_ACC_L;
         end
         S_ACC_L: begin
            dv_in    = prod_sh8[24:0];
            state_in = S_PV;
         end
         S_PV: begin
            mul_a    = 36'(spd_ff);
            mul_b    = {16'd0, dt_ff};
            state_in = S_HROT;
         end
         S_HROT: begin
            pv_in         = prod_sh8[31:0];
            cor_cmd.start = 1'b1;
            cor_cmd.angle = hdg_ff + slip_ff;
            state_in      = S_HROT_WAIT;
         end
         S_HROT_WAIT: begin
            if (cor_done) begin
               c_in     = cor_cos;
               s_in     = cor_sin;
               state_in = S_Q1;
            end
         end
         S_Q1: begin
            mul_a    = 36'(pv_ff);
            mul_b    = sin_slip_ff;
            state_in = S_NUM;
         end
         S_NUM: begin
            mul_a    = prod_sh28[35:0];
            mul_b    = RAD_TO_BAM;
            state_in = S_DIV;
         end
         S_DIV: begin
            div_start = 1'b1;
            neg_in    = prod_ff[PROD_W-1];
            mul_a     = 36'(pv_ff);
            mul_b     = c_ff;
            state_in  = S_X;
         end
         S_X: begin
            x_in     = x_new;
            mul_a    = 36'(pv_ff);
            mul_b    = s_ff;
            state_in = S_Y;
         end
         S_Y: begin
            y_in     = y_new;
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done && slot_free) begin
               hdg_in       = hdg_new;
               spd_in       = spd_new;
               tick_in      = tick_ff + 32'd1;
               left_in      = left_ff - 7'd1;
               rsp_valid_in = 1'b1;
               rsp_last_in  = last_step;
               rsp_data_in  = {hdg_new, spd_new, y_ff, x_ff, tick_ff + 32'd1};
               state_in     = last_step ? S_IDLE : S_PV;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= FRONT_RESET;
         rear_ff      <= REAR_RESET;
         dt_ff        <= DT_RESET;
         x_ff         <= '0;
         y_ff         <= '0;
         spd_ff       <= '0;
         hdg_ff       <= '0;
         tick_ff      <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         rear_ff      <= rear_in;
         dt_ff        <= dt_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         spd_ff       <= spd_in;
         hdg_ff       <= hdg_in;
         tick_ff      <= tick_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      accel_ff    <= accel_in;
      steer_ff    <= steer_in;
      slip_ff     <= slip_in;
      c_ff        <= c_in;
      s_ff        <= s_in;
      sin_slip_ff <= sin_slip_in;
      pv_ff       <= pv_in;
      dv_ff       <= dv_in;
      vy_ff       <= vy_in;
      neg_ff      <= neg_in;
      rsp_last_ff <= rsp_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   `KBS_ASSERT_NEXT(a_load_answers, accept && !req_tuser, rsp_tvalid && rsp_tlast)
   `KBS_ASSERT_IMP(a_mid_run_busy, rsp_tvalid && rsp_tready && !rsp_tlast, state_ff != S_IDLE)
   `KBS_ASSERT_IMP(a_steps_bounded, state_ff != S_IDLE, left_ff <= 7'(MAX_STEPS) && left_ff != 7'd0)

endmodule
